[src/assert_macros.svh]
// Assertion helpers used by the crossfader core.
// Each expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[src/sdc_pkg.sv]
package sdc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FADE_W     = 19;
  localparam int MAX_FADE   = 262144;
  localparam int POS_W      = $clog2(MAX_FADE);
  localparam int FADE_RESET = 3 * 44100;

  // Serial blend unit sizing
  localparam int MUL_STEPS = FADE_W;
  localparam int DIV_STEPS = SAMPLE_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);
  localparam int HI_W      = SAMPLE_W + 4;
  localparam int PROD_W    = HI_W + FADE_W;
  localparam int MAG_W     = SAMPLE_W + POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_BLEND,
    S_EMIT
  } sdc_state_e;

  typedef enum logic [2:0] {
    BL_IDLE,
    BL_MUL,
    BL_ABS,
    BL_DIV,
    BL_DONE
  } bl_phase_e;

  typedef logic [FADE_W-1:0] fade_t;

endpackage

[src/sdc_ram.sv]
module sdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/sdc_blend.sv]
module sdc_blend import sdc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SAMPLE_W-1:0] old_i,
  input  logic [SAMPLE_W-1:0] cur_i,
  input  fade_t               wt_old_i,
  input  fade_t               wt_cur_i,
  input  fade_t               div_i,
  output logic                done_o,
  output logic [SAMPLE_W-1:0] res_o
);

  bl_phase_e phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [SAMPLE_W-1:0] old_q, cur_q;
  fade_t               wo_q, wc_q, div_q;
  logic [HI_W-1:0]     hi_q;
  logic [FADE_W-1:0]   lo_q;
  logic                neg_q;
  fade_t               rem_q;
  logic [SAMPLE_W-1:0] quo_q;

  logic [SAMPLE_W:0]   term;
  logic [HI_W-1:0]     hsum;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   mag;
  fade_t               trial;
  logic                ge;
  logic                mul_last, div_last;

  assign mul_last = (cnt_q == CNT_W'(MUL_STEPS - 1));
  assign div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

  // One weight bit of each operand per cycle, accumulated at the top and shifted down
  always_comb begin
    term = (wo_q[0] ? {old_q[SAMPLE_W-1], old_q} : '0)
         + (wc_q[0] ? {cur_q[SAMPLE_W-1], cur_q} : '0);
    hsum = hi_q + {{(HI_W-SAMPLE_W-1){term[SAMPLE_W]}}, term};
    prod = {hi_q, lo_q};
    mag  = prod[PROD_W-1] ? (~prod + PROD_W'(1)) : prod;
    trial = {rem_q[FADE_W-2:0], quo_q[SAMPLE_W-1]};
    ge    = (trial >= div_q);
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    case (phase_q)
      BL_IDLE: begin
        if (start_i) begin
          phase_d = BL_MUL;
          cnt_d   = '0;
        end
      end
      BL_MUL: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (mul_last) begin
          phase_d = BL_ABS;
        end
      end
      BL_ABS: begin
        phase_d = BL_DIV;
        cnt_d   = '0;
      end
      BL_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (div_last) begin
          phase_d = BL_DONE;
        end
      end
      BL_DONE: phase_d = BL_IDLE;
      default: phase_d = BL_IDLE;
    endcase
  end

  always_comb begin
    done_o = 1'b0;
    res_o  = '0;
    case (phase_q)
      BL_DONE: begin
        done_o = 1'b1;
        res_o  = neg_q ? (~quo_q + SAMPLE_W'(1)) : quo_q;
      end
      default: begin
        done_o = 1'b0;
        res_o  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= BL_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      BL_IDLE: begin
        if (start_i) begin
          old_q <= old_i;
          cur_q <= cur_i;
          wo_q  <= wt_old_i;
          wc_q  <= wt_cur_i;
          div_q <= div_i;
          hi_q  <= '0;
          lo_q  <= '0;
        end
      end
      BL_MUL: begin
        hi_q <= {hsum[HI_W-1], hsum[HI_W-1:1]};
        lo_q <= {hsum[0], lo_q[FADE_W-1:1]};
        wo_q <= wo_q >> 1;
        wc_q <= wc_q >> 1;
      end
      BL_ABS: begin
        // Quotient fits in the sample width, so the top bits start below the divisor
        neg_q <= prod[PROD_W-1];
        rem_q <= {1'b0, mag[MAG_W-1:SAMPLE_W]};
        quo_q <= mag[SAMPLE_W-1:0];
      end
      BL_DIV: begin
        rem_q <= ge ? (trial - div_q) : trial;
        quo_q <= {quo_q[SAMPLE_W-2:0], ge};
      end
      default: begin
      end
    endcase
  end

endmodule

[src/stereo_delay_crossfader_core.sv]
// Stereo delay line with linear crossfade on a new-track mark.
// Input channel (in_valid_i/in_ready_o): action_i, left_in_i, right_in_i,
// last_in_block_i. Output channel (out_valid_o/out_ready_i): left_out_o,
// right_out_o. cfg_we_i writes cfg_wdata_i as the fade and delay length.
// A transaction is taken only in the idle state. A mark or a sample that
// still fills the delay line is handled in the idle state and yields
// nothing. A sample through a full line passes memory read, swap and load
// of the output register. A sample during a fade passes memory read, start
// of the blend, the bit-serial multiplier (one weight bit per cycle), a
// sign step, the restoring divider (one quotient bit per cycle), hand-on
// of the quotient and the output load; both channels run in parallel.
// The output register decouples the sides: a new transaction is taken while
// a result waits, and a following result holds in the emit state until the
// receiver takes the pending one.
// Reset clears position, fill count and fade countdown and sets the length
// to 132300; the delay memory is not cleared and every entry is written
// before it is read.
`include "assert_macros.svh"

module stereo_delay_crossfader_core import sdc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [SAMPLE_W-1:0] left_in_i,
  input  logic [SAMPLE_W-1:0] right_in_i,
  input  logic                last_in_block_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SAMPLE_W-1:0] left_out_o,
  output logic [SAMPLE_W-1:0] right_out_o,
  input  logic                cfg_we_i,
  input  fade_t               cfg_wdata_i
);

  sdc_state_e state_q, state_d;

  fade_t             fade_cfg_q;
  logic [POS_W-1:0]  ring_pos_q, ring_pos_d;
  fade_t             fill_cnt_q, fill_cnt_d;
  fade_t             fade_rem_q, fade_rem_d;
  logic              blend_mode_q, blend_mode_d;
  logic              out_valid_q;

  logic [POS_W-1:0]    pos_q;
  logic [SAMPLE_W-1:0] l_q, r_q;
  fade_t               wt_old_q, wt_cur_q, div_q;
  logic [SAMPLE_W-1:0] res_l_q, res_r_q;
  logic [SAMPLE_W-1:0] out_l_q, out_r_q;

  fade_t            f_eff, rem_lim, pos_inc, rem_dec;
  logic [POS_W-1:0] pos, pos_next;
  logic             acc, is_sample, fading, filling;

  logic                    ram_we, ram_re;
  logic [POS_W-1:0]        ram_addr;
  logic [2*SAMPLE_W-1:0]   ram_wdata, ram_rdata;

  logic                blend_start, out_load;
  logic                done_l, done_r;
  logic [SAMPLE_W-1:0] blend_l, blend_r;

  // last_in_block_i marks software block edges and carries nothing for the datapath

  always_comb begin
    if (fade_cfg_q == '0) begin
      f_eff = FADE_W'(1);
    end else if (fade_cfg_q > FADE_W'(MAX_FADE)) begin
      f_eff = FADE_W'(MAX_FADE);
    end else begin
      f_eff = fade_cfg_q;
    end
    pos      = ({1'b0, ring_pos_q} >= f_eff) ? '0 : ring_pos_q;
    pos_inc  = {1'b0, pos} + FADE_W'(1);
    pos_next = (pos_inc >= f_eff) ? '0 : pos_inc[POS_W-1:0];
    rem_lim  = (fade_rem_q > f_eff) ? f_eff : fade_rem_q;
    rem_dec  = rem_lim - FADE_W'(1);
    fading   = (fade_rem_q != '0);
    filling  = (fill_cnt_q < f_eff);
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign is_sample  = !action_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc && is_sample && (fading || !filling)) begin
          state_d = S_READ;
        end
      end
      S_READ:  state_d = blend_mode_q ? S_BLEND : S_EMIT;
      S_BLEND: begin
        if (done_l) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and memory control
  always_comb begin
    blend_start = 1'b0;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = pos;
    ram_wdata   = {left_in_i, right_in_i};
    case (state_q)
      S_IDLE: begin
        ram_we     = acc && is_sample && !fading && filling;
        ram_re     = acc && is_sample && (fading || !filling);
      end
      S_READ: begin
        ram_addr    = pos_q;
        ram_wdata   = {l_q, r_q};
        ram_we      = !blend_mode_q;
        blend_start = blend_mode_q;
      end
      S_EMIT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ring_pos_d   = ring_pos_q;
    fill_cnt_d   = fill_cnt_q;
    fade_rem_d   = fade_rem_q;
    blend_mode_d = blend_mode_q;
    if (acc) begin
      ring_pos_d = pos;
      if (!is_sample) begin
        fade_rem_d = filling ? '0 : f_eff;
      end else if (fading) begin
        ring_pos_d   = pos_next;
        fade_rem_d   = rem_dec;
        blend_mode_d = 1'b1;
        if (rem_dec == '0) begin
          fill_cnt_d = '0;
        end
      end else if (filling) begin
        ring_pos_d = pos_next;
        fill_cnt_d = fill_cnt_q + FADE_W'(1);
      end else begin
        ring_pos_d   = pos_next;
        blend_mode_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fade_cfg_q   <= FADE_W'(FADE_RESET);
      ring_pos_q   <= '0;
      fill_cnt_q   <= '0;
      fade_rem_q   <= '0;
      blend_mode_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ring_pos_q   <= ring_pos_d;
      fill_cnt_q   <= fill_cnt_d;
      fade_rem_q   <= fade_rem_d;
      blend_mode_q <= blend_mode_d;
      if (cfg_we_i) begin
        fade_cfg_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pos_q    <= pos;
      l_q      <= left_in_i;
      r_q      <= right_in_i;
      wt_old_q <= rem_lim;
      wt_cur_q <= f_eff - rem_lim;
      div_q    <= f_eff;
    end
    if ((state_q == S_READ) && !blend_mode_q) begin
      res_l_q <= ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
      res_r_q <= ram_rdata[SAMPLE_W-1:0];
    end
    if ((state_q == S_BLEND) && done_l) begin
      res_l_q <= blend_l;
      res_r_q <= blend_r;
    end
    if (out_load) begin
      out_l_q <= res_l_q;
      out_r_q <= res_r_q;
    end
  end

  sdc_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (MAX_FADE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  sdc_blend u_blend_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (blend_start),
    .old_i    (ram_rdata[2*SAMPLE_W-1:SAMPLE_W]),
    .cur_i    (l_q),
    .wt_old_i (wt_old_q),
    .wt_cur_i (wt_cur_q),
    .div_i    (div_q),
    .done_o   (done_l),
    .res_o    (blend_l)
  );

  sdc_blend u_blend_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (blend_start),
    .old_i    (ram_rdata[SAMPLE_W-1:0]),
    .cur_i    (r_q),
    .wt_old_i (wt_old_q),
    .wt_cur_i (wt_cur_q),
    .div_i    (div_q),
    .done_o   (done_r),
    .res_o    (blend_r)
  );

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

  `SDC_ASSERT(a_fade_within_fill, fade_rem_q <= fill_cnt_q, "fade countdown exceeds fill count")
  `SDC_ASSERT(a_fill_bound, fill_cnt_q <= FADE_W'(MAX_FADE), "fill count beyond store depth")
  `SDC_ASSERT(a_blend_lockstep, done_l |-> (done_r && (state_q == S_BLEND)), "blend units out of step")
  `SDC_ASSERT_NEXT(a_read_follows, ram_re, state_q == S_READ, "memory read without read state")

endmodule
